// ===== rtl/core/rbr_pkg.sv =====
// ----------------------------------------------------------------------------
// rbr_pkg
// Shared widths, operation and status codes, and payload types of the
// circular reorder buffer.
// ----------------------------------------------------------------------------
package rbr_pkg;

  // Field widths fixed by the interface.
  localparam int OP_W   = 3;
  localparam int ST_W   = 3;
  localparam int IDX_W  = 4;
  localparam int WORD_W = 32;

  // Default depth and the widest entry address any depth can need.
  localparam int NUM_ENTRIES_DEF = 16;
  localparam int ADDR_MAX_W      = 8;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
  localparam logic [OP_W-1:0] OP_POP   = 3'd1;
  localparam logic [OP_W-1:0] OP_WRITE = 3'd2;
  localparam logic [OP_W-1:0] OP_FLUSH = 3'd3;
  localparam logic [OP_W-1:0] OP_QUERY = 3'd4;

  // Status codes.
  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [ST_W-1:0] ST_NOT_READY = 3'd3;
  localparam logic [ST_W-1:0] ST_INVALID   = 3'd4;

  // Input word.
  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [WORD_W-1:0] inst_word;
    logic              ready_on_entry;
    logic [IDX_W-1:0]  entry_index;
    logic              actual_taken;
    logic              mispredict_flag;
    logic [WORD_W-1:0] result_value;
    logic [WORD_W-1:0] jump_target;
  } rbr_in_t;

  // Result word.
  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [IDX_W-1:0]  pushed_index;
    logic              can_push;
    logic              can_pop;
    logic [IDX_W-1:0]  head_index;
    logic [WORD_W-1:0] head_inst;
    logic              head_taken;
    logic              head_mispredict;
    logic [WORD_W-1:0] head_target;
    logic [WORD_W-1:0] sel_result;
    logic              sel_ready;
  } rbr_out_t;

  // Writeback state held for each entry.
  typedef struct packed {
    logic              taken;
    logic              mispredict;
    logic [WORD_W-1:0] target;
    logic [WORD_W-1:0] result;
  } rbr_wb_t;

  // Write and read controls from the pointer logic to the entry storage.
  typedef struct packed {
    logic                  inst_we;
    logic [ADDR_MAX_W-1:0] inst_addr;
    logic                  wb_we;
    logic [ADDR_MAX_W-1:0] wb_addr;
    logic [ADDR_MAX_W-1:0] head_addr;
    logic [ADDR_MAX_W-1:0] query_addr;
  } rbr_mem_ctl_t;

  // Control and status outcome of one operation.
  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [IDX_W-1:0] pushed_index;
    logic             can_push;
    logic             can_pop;
    logic [IDX_W-1:0] head_index;
    logic             queried;
    logic             query_in_range;
    logic             sel_ready;
  } rbr_step_t;

endpackage

// ===== rtl/core/rbr_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbr_ctrl
// Head and tail pointers, per-entry valid and ready bits, and the decode of
// one operation into status, storage writes and storage read addresses.
// ----------------------------------------------------------------------------
module rbr_ctrl
  import rbr_pkg::*;
#(
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  rbr_in_t      item,
  output rbr_step_t    step,
  output rbr_mem_ctl_t mem_ctl
);

  localparam int PTR_W = $clog2(NUM_ENTRIES);
  localparam int CMP_W = (PTR_W > IDX_W) ? PTR_W : IDX_W;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(NUM_ENTRIES - 1);

  logic [NUM_ENTRIES-1:0] valid_r, valid_nxt;
  logic [NUM_ENTRIES-1:0] ready_r, ready_nxt;
  logic [PTR_W-1:0]       head_r, head_nxt;
  logic [PTR_W-1:0]       tail_r, tail_nxt;
  logic [PTR_W-1:0]       idx_p;
  logic [PTR_W-1:0]       pushed;
  logic [CMP_W:0]         idx_w;
  logic [ST_W-1:0]        status;
  logic                   in_range;
  logic                   full, empty;
  logic                   full_after, empty_after;
  logic                   queried, inst_we, wb_we;

  // Next pointer position around the ring.
  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    return (p == LAST) ? '0 : p + 1'b1;
  endfunction

  // Entry index, range-checked against the configured depth.
  assign idx_w    = (CMP_W + 1)'(item.entry_index);
  assign in_range = idx_w < (CMP_W + 1)'(NUM_ENTRIES);
  assign idx_p    = idx_w[PTR_W-1:0];

  // Full and empty come from pointer equality and the valid bit there.
  assign full  = (tail_r == head_r) && valid_r[tail_r];
  assign empty = (tail_r == head_r) && !valid_r[head_r];

  // Operation decode and next state.
  always_comb begin
    valid_nxt = valid_r;
    ready_nxt = ready_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    status    = ST_OK;
    pushed    = '0;
    queried   = 1'b0;
    inst_we   = 1'b0;
    wb_we     = 1'b0;
    case (item.operation)
      OP_PUSH: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          valid_nxt[tail_r] = 1'b1;
          ready_nxt[tail_r] = item.ready_on_entry;
          pushed            = tail_r;
          tail_nxt          = advance(tail_r);
          inst_we           = 1'b1;
        end
      end
      OP_POP: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          if (!ready_r[head_r]) begin
            status = ST_NOT_READY;
          end
          valid_nxt[head_r] = 1'b0;
          head_nxt          = advance(head_r);
        end
      end
      OP_WRITE: begin
        if (!in_range || !valid_r[idx_p]) begin
          status = ST_INVALID;
        end else begin
          ready_nxt[idx_p] = 1'b1;
          wb_we            = 1'b1;
        end
      end
      OP_FLUSH: begin
        valid_nxt = '0;
        head_nxt  = '0;
        tail_nxt  = '0;
      end
      OP_QUERY: begin
        queried = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Occupancy after the operation.
  assign full_after  = (tail_nxt == head_nxt) && valid_nxt[tail_nxt];
  assign empty_after = (tail_nxt == head_nxt) && !valid_nxt[head_nxt];

  // Outcome of the operation.
  always_comb begin
    step.status         = status;
    step.pushed_index   = IDX_W'(pushed);
    step.can_push       = !full_after;
    step.can_pop        = !empty_after;
    step.head_index     = IDX_W'(head_nxt);
    step.queried        = queried;
    step.query_in_range = in_range;
    if (queried) begin
      step.sel_ready = in_range && ready_nxt[idx_p];
    end else begin
      step.sel_ready = !empty_after && ready_nxt[head_nxt];
    end
  end

  // Storage writes go to the tail or the addressed entry; reads look at the
  // head as it stands after the operation.
  always_comb begin
    mem_ctl.inst_we    = inst_we;
    mem_ctl.inst_addr  = ADDR_MAX_W'(tail_r);
    mem_ctl.wb_we      = wb_we;
    mem_ctl.wb_addr    = ADDR_MAX_W'(idx_p);
    mem_ctl.head_addr  = ADDR_MAX_W'(head_nxt);
    mem_ctl.query_addr = ADDR_MAX_W'(idx_p);
  end

  // Valid bits and pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      head_r  <= '0;
      tail_r  <= '0;
    end else if (en) begin
      valid_r <= valid_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
    end
  end

  // Ready marks are only meaningful once an entry is pushed.
  always_ff @(posedge clk) begin
    if (en) begin
      ready_r <= ready_nxt;
    end
  end

endmodule

// ===== rtl/core/rbr_store.sv =====
// ----------------------------------------------------------------------------
// rbr_store
// Entry storage: an instruction memory written at the tail and a writeback
// memory written by index, with registered reads at the head and at the
// queried entry. A write in the same cycle is forwarded to a matching read.
// ----------------------------------------------------------------------------
module rbr_store
  import rbr_pkg::*;
#(
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              en,
  input  rbr_mem_ctl_t      mem_ctl,
  input  logic [WORD_W-1:0] inst_wdata,
  input  rbr_wb_t           wb_wdata,
  output logic [WORD_W-1:0] head_inst,
  output rbr_wb_t           head_wb,
  output logic [WORD_W-1:0] query_result
);

  localparam int PTR_W = $clog2(NUM_ENTRIES);

  logic [WORD_W-1:0] inst_mem [NUM_ENTRIES];
  rbr_wb_t           wb_mem   [NUM_ENTRIES];

  logic [PTR_W-1:0]  inst_addr, wb_addr, head_addr, query_addr;
  logic [WORD_W-1:0] head_inst_r;
  rbr_wb_t           head_wb_r;
  logic [WORD_W-1:0] query_result_r;

  assign inst_addr  = mem_ctl.inst_addr[PTR_W-1:0];
  assign wb_addr    = mem_ctl.wb_addr[PTR_W-1:0];
  assign head_addr  = mem_ctl.head_addr[PTR_W-1:0];
  assign query_addr = mem_ctl.query_addr[PTR_W-1:0];

  // Memory writes.
  always_ff @(posedge clk) begin
    if (en && mem_ctl.inst_we) begin
      inst_mem[inst_addr] <= inst_wdata;
    end
    if (en && mem_ctl.wb_we) begin
      wb_mem[wb_addr] <= wb_wdata;
    end
  end

  // Registered reads with write-first forwarding; they hold while stalled.
  always_ff @(posedge clk) begin
    if (en) begin
      if (mem_ctl.inst_we && (inst_addr == head_addr)) begin
        head_inst_r <= inst_wdata;
      end else begin
        head_inst_r <= inst_mem[head_addr];
      end
      if (mem_ctl.wb_we && (wb_addr == head_addr)) begin
        head_wb_r <= wb_wdata;
      end else begin
        head_wb_r <= wb_mem[head_addr];
      end
      if (mem_ctl.wb_we && (wb_addr == query_addr)) begin
        query_result_r <= wb_wdata.result;
      end else begin
        query_result_r <= wb_mem[query_addr].result;
      end
    end
  end

  assign head_inst    = head_inst_r;
  assign head_wb      = head_wb_r;
  assign query_result = query_result_r;

endmodule

// ===== rtl/core/reorder_buffer_ring.sv =====
// ----------------------------------------------------------------------------
// reorder_buffer_ring
// Circular reorder buffer with push, pop, writeback, flush and query.
//
//   Channel   Ports                           Word
//   input     in_valid, in_ready, in_data     rbr_in_t, one operation
//   result    out_valid, out_ready, out_data  rbr_out_t, one per operation
//
// One operation is accepted every cycle unless the result channel stalls;
// its result passes the input register, then the result register and the
// storage read, and is then offered on the result channel.
// The buffer state commits in the cycle an operation moves into the result
// register, so back-to-back operations see each other's effects.
// Reset clears the valid bits and both pointers; entry data is not cleared.
// While out_ready is low the result holds and one more operation waits in
// the input register.
// ----------------------------------------------------------------------------
module reorder_buffer_ring
  import rbr_pkg::*;
#(
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  rbr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output rbr_out_t out_data
);

  logic              in_vld_r, in_vld_nxt;
  rbr_in_t           in_r;
  logic              out_vld_r, out_vld_nxt;
  rbr_step_t         step_r;
  rbr_step_t         step;
  rbr_mem_ctl_t      mem_ctl;
  rbr_wb_t           wb_wdata;
  rbr_wb_t           head_wb;
  logic [WORD_W-1:0] head_inst;
  logic [WORD_W-1:0] query_result;
  logic              advance;

  // Pipeline handshake.
  assign advance    = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready   = !in_vld_r || advance;
  assign in_vld_nxt = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : in_vld_r);
  assign out_vld_nxt = advance ? 1'b1 : (out_ready ? 1'b0 : out_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  // Pointer and flag logic.
  rbr_ctrl #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (advance),
    .item   (in_r),
    .step   (step),
    .mem_ctl(mem_ctl)
  );

  // Entry storage.
  always_comb begin
    wb_wdata.taken      = in_r.actual_taken;
    wb_wdata.mispredict = in_r.mispredict_flag;
    wb_wdata.target     = in_r.jump_target;
    wb_wdata.result     = in_r.result_value;
  end

  rbr_store #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) u_store (
    .clk         (clk),
    .en          (advance),
    .mem_ctl     (mem_ctl),
    .inst_wdata  (in_r.inst_word),
    .wb_wdata    (wb_wdata),
    .head_inst   (head_inst),
    .head_wb     (head_wb),
    .query_result(query_result)
  );

  // Result register for the control outcome.
  always_ff @(posedge clk) begin
    if (advance) begin
      step_r <= step;
    end
  end

  // Result word: head fields read as zero when the buffer is empty.
  always_comb begin
    out_data.status          = step_r.status;
    out_data.pushed_index    = step_r.pushed_index;
    out_data.can_push        = step_r.can_push;
    out_data.can_pop         = step_r.can_pop;
    out_data.head_index      = step_r.head_index;
    out_data.head_inst       = step_r.can_pop ? head_inst : '0;
    out_data.head_taken      = step_r.can_pop && head_wb.taken;
    out_data.head_mispredict = step_r.can_pop && head_wb.mispredict;
    out_data.head_target     = step_r.can_pop ? head_wb.target : '0;
    if (step_r.queried) begin
      out_data.sel_result = step_r.query_in_range ? query_result : '0;
    end else begin
      out_data.sel_result = step_r.can_pop ? head_wb.result : '0;
    end
    out_data.sel_ready = step_r.sel_ready;
  end

  assign out_valid = out_vld_r;

endmodule

// ===== rtl/core/rbr_checker.sv =====
// ----------------------------------------------------------------------------
// rbr_checker
// Port-level checks of the reorder buffer's result channel, bound to the
// top level.
// ----------------------------------------------------------------------------
module rbr_checker
  import rbr_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_ready,
  input rbr_out_t out_data
);

  // A stalled result word holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // A rejected push leaves the buffer full.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_FULL) |-> !out_data.can_push)
    else $error("push rejected but buffer reported not full");

  // A rejected pop leaves the buffer empty.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_EMPTY) |-> !out_data.can_pop)
    else $error("pop rejected but buffer reported not empty");

  // A full buffer is never empty.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.can_push |-> out_data.can_pop)
    else $error("buffer reported full and empty at once");

  // An empty buffer shows a cleared head entry.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.can_pop |->
      (out_data.head_inst == '0) && (out_data.head_target == '0) &&
      !out_data.head_taken && !out_data.head_mispredict)
    else $error("head fields not cleared while empty");

endmodule

bind reorder_buffer_ring rbr_checker u_rbr_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
